@@ rtl/core/rotation_matrix_to_quaternion_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT(lbl, prop)
`define RMQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ rtl/core/rmq_pkg.sv @@
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants and the branch code of the matrix to quaternion block.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

endpackage

@@ rtl/core/rmq_front.sv @@
// ---------------------------------------------------------------------------
// rmq_front
// Branch decode: trace test, largest diagonal, square-root argument and the
// off-diagonal numerators of the chosen branch.
// ---------------------------------------------------------------------------
module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic signed [DATA_WIDTH+2:0] arg,
  output rmq_pkg::branch_t             br,
  output logic signed [DATA_WIDTH:0]   num [4]
);
  import rmq_pkg::*;

  localparam int AW  = DATA_WIDTH + 3;
  localparam int NMW = DATA_WIDTH + 1;

  logic signed [AW-1:0]  e00, e11, e22, trace, one;
  logic signed [NMW-1:0] f01, f02, f10, f12, f20, f21;

  always_comb begin
    e00   = AW'(m00);
    e11   = AW'(m11);
    e22   = AW'(m22);
    f01   = NMW'(m01);
    f02   = NMW'(m02);
    f10   = NMW'(m10);
    f12   = NMW'(m12);
    f20   = NMW'(m20);
    f21   = NMW'(m21);
    one   = AW'(1) <<< FRAC_BITS;
    trace = e00 + e11 + e22;
    num[0] = '0;
    num[1] = '0;
    num[2] = '0;
    num[3] = '0;
    if (trace > 0) begin
      br     = BR_TRACE;
      arg    = trace + one;
      num[1] = f12 - f21;
      num[2] = f20 - f02;
      num[3] = f01 - f10;
    end else if (e00 > e11 && e00 > e22) begin
      br     = BR_X;
      arg    = one + e00 - e11 - e22;
      num[0] = f12 - f21;
      num[2] = f10 + f01;
      num[3] = f20 + f02;
    end else if (e11 > e22) begin
      br     = BR_Y;
      arg    = one + e11 - e00 - e22;
      num[0] = f20 - f02;
      num[1] = f10 + f01;
      num[3] = f21 + f12;
    end else begin
      br     = BR_Z;
      arg    = one + e22 - e00 - e11;
      num[0] = f01 - f10;
      num[1] = f20 + f02;
      num[2] = f21 + f12;
    end
  end

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion by the four-branch trace method.
// ---------------------------------------------------------------------------
// One matrix word is taken per cycle and one quaternion word leaves per cycle
// while the output is not stalled. The stages are one decode stage, one
// square-root stage per root bit (RW = (DATA_WIDTH + FRAC_BITS + 3) / 2 root
// bits), one divider setup stage, one stage per quotient bit of the four
// parallel dividers, and the saturating output register. The whole pipeline
// advances together and holds while a finished word waits at the output.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_qw,
  output logic signed [DATA_WIDTH-1:0] out_qx,
  output logic signed [DATA_WIDTH-1:0] out_qy,
  output logic signed [DATA_WIDTH-1:0] out_qz,
  output logic [1:0]                   out_branch_taken,
  output logic                         out_degenerate
);
  import rmq_pkg::*;

  localparam int SW_RAW = DATA_WIDTH + FRAC_BITS + 2;
  localparam int RW     = (SW_RAW + 1) / 2;
  localparam int SW     = 2 * RW;
  localparam int NW     = DATA_WIDTH + 1 + FRAC_BITS;
  localparam int DVW    = RW + 1;
  localparam int CW     = ((NW > DVW + DATA_WIDTH) ? NW : DVW + DATA_WIDTH) + 1;
  localparam int NST    = RW + DATA_WIDTH + 3;
  localparam int SETUP  = RW + 1;
  localparam int LAST   = NST - 1;

  localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    branch_t                         br;
    logic                            degen;
    logic [SW-1:0]                   x;
    logic [SW-1:0]                   res;
    logic [DVW-1:0]                  dv;
    logic [3:0]                      neg;
    logic [3:0]                      zero;
    logic [3:0]                      ovf;
    logic [3:0][NW-1:0]              rem;
    logic [3:0][DATA_WIDTH-1:0]      quo;
  } stage_t;

  logic signed [DATA_WIDTH+2:0] f_arg;
  branch_t                      f_br;
  logic signed [DATA_WIDTH:0]   f_num [4];

  stage_t         st_r   [NST];
  stage_t         st_nxt [NST];
  logic [NST-1:0] vld_r;
  logic           en;

  rmq_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .m00(in_m00), .m01(in_m01), .m02(in_m02),
    .m10(in_m10), .m11(in_m11), .m12(in_m12),
    .m20(in_m20), .m21(in_m21), .m22(in_m22),
    .arg(f_arg),
    .br (f_br),
    .num(f_num)
  );

  assign en       = !vld_r[LAST] || out_ready;
  assign in_ready = en;

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_stage
      if (s == 0) begin : g_decode
        logic [DATA_WIDTH:0] mag [4];
        always_comb begin
          st_nxt[s]       = '0;
          st_nxt[s].br    = f_br;
          st_nxt[s].degen = (f_arg <= 0);
          st_nxt[s].x     = (f_arg > 0) ? (SW'(f_arg) << FRAC_BITS) : '0;
          for (int k = 0; k < 4; k++) begin
            mag[k]              = f_num[k][DATA_WIDTH] ? $unsigned(-f_num[k])
                                                      : $unsigned(f_num[k]);
            st_nxt[s].neg[k]    = f_num[k][DATA_WIDTH];
            st_nxt[s].zero[k]   = (f_num[k] == '0);
            st_nxt[s].rem[k]    = NW'(mag[k]) << FRAC_BITS;
          end
        end
      end else if (s <= RW) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RW - s));
        logic [SW-1:0] tr;
        always_comb begin
          st_nxt[s] = st_r[s-1];
          tr        = st_r[s-1].res + BIT;
          if (st_r[s-1].x >= tr) begin
            st_nxt[s].x   = st_r[s-1].x - tr;
            st_nxt[s].res = (st_r[s-1].res >> 1) + BIT;
          end else begin
            st_nxt[s].res = st_r[s-1].res >> 1;
          end
        end
      end else if (s == SETUP) begin : g_setup
        logic [DVW-1:0] dv;
        always_comb begin
          st_nxt[s]    = st_r[s-1];
          dv           = {st_r[s-1].res[RW-1:0], 1'b0};
          st_nxt[s].dv = dv;
          for (int k = 0; k < 4; k++) begin
            st_nxt[s].ovf[k] = CW'(st_r[s-1].rem[k]) >= (CW'(dv) << DATA_WIDTH);
          end
        end
      end else if (s < LAST) begin : g_div
        localparam int QB = DATA_WIDTH - 1 - (s - SETUP - 1);
        logic [CW-1:0] sh;
        always_comb begin
          st_nxt[s] = st_r[s-1];
          sh        = CW'(st_r[s-1].dv) << QB;
          for (int k = 0; k < 4; k++) begin
            if (CW'(st_r[s-1].rem[k]) >= sh) begin
              st_nxt[s].rem[k]     = st_r[s-1].rem[k] - NW'(sh);
              st_nxt[s].quo[k][QB] = 1'b1;
            end
          end
        end
      end else begin : g_out
        logic [RW-2:0] rh;
        always_comb begin
          st_nxt[s] = st_r[s-1];
          rh        = st_r[s-1].res[RW-1:1];
          for (int k = 0; k < 4; k++) begin
            if (k == int'(st_r[s-1].br)) begin
              if (st_r[s-1].degen) begin
                st_nxt[s].quo[k] = '0;
              end else if (CW'(rh) > CW'(SMAX)) begin
                st_nxt[s].quo[k] = SMAX;
              end else begin
                st_nxt[s].quo[k] = DATA_WIDTH'(rh);
              end
            end else if (st_r[s-1].zero[k]) begin
              st_nxt[s].quo[k] = '0;
            end else if (st_r[s-1].neg[k]) begin
              if (st_r[s-1].ovf[k] || st_r[s-1].quo[k] > SMIN) begin
                st_nxt[s].quo[k] = SMIN;
              end else begin
                st_nxt[s].quo[k] = -st_r[s-1].quo[k];
              end
            end else begin
              if (st_r[s-1].ovf[k] || st_r[s-1].quo[k][DATA_WIDTH-1]) begin
                st_nxt[s].quo[k] = SMAX;
              end else begin
                st_nxt[s].quo[k] = st_r[s-1].quo[k];
              end
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[s] <= st_nxt[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign out_valid        = vld_r[LAST];
  assign out_qw           = st_r[LAST].quo[0];
  assign out_qx           = st_r[LAST].quo[1];
  assign out_qy           = st_r[LAST].quo[2];
  assign out_qz           = st_r[LAST].quo[3];
  assign out_branch_taken = st_r[LAST].br;
  assign out_degenerate   = st_r[LAST].degen;

  `RMQ_ASSERT(a_degen_main_zero, out_valid && out_degenerate |-> st_r[LAST].quo[out_branch_taken] == '0)
  `RMQ_ASSERT(a_main_nonneg, out_valid && !out_degenerate |-> !st_r[LAST].quo[out_branch_taken][DATA_WIDTH-1])
  `RMQ_ASSERT_NEXT(a_stall_holds_pipe, vld_r[LAST] && !out_ready, $stable(vld_r))

endmodule

@@ sim/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Feeds matrix words through a table of directed cases and then random
// matrices (unit-range, diagonal-heavy and raw noise), with bursty input
// and a stalling receiver. Each quaternion word is checked in order against
// typed-in values or an in-bench fixed point four-branch trace prediction.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int NDIR = 14;
  localparam int NRAND = 1450;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [DW-1:0] fix_t;
  typedef struct {
    fix_t m [9];
  } matrix_t;
  typedef struct {
    fix_t qw, qx, qy, qz;
    branch_t br;
    logic degen;
  } quat_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  fix_t in_m [9];
  fix_t out_qw, out_qx, out_qy, out_qz;
  logic [1:0] out_branch_taken;
  logic out_degenerate;

  quat_t quat_q [$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_branch_taken(out_branch_taken), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
        r = r + (longint'(1) << b);
    end
    return r;
  endfunction

  function automatic longint clamp(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint off_term(longint n, longint r);
    longint mag, quot;
    if (r == 0) return (n > 0) ? SMAX : (n < 0) ? SMIN : 0;
    mag = (n < 0) ? -n : n;
    quot = (mag << FB) / (r << 1);
    return clamp((n < 0) ? -quot : quot);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t a);
    longint e [9];
    longint trace, arg, r;
    longint n [4];
    longint q [4];
    int b;
    quat_t res;
    for (int i = 0; i < 9; i++) e[i] = a.m[i];
    trace = e[0] + e[4] + e[8];
    if (trace > 0) begin
      b = BR_TRACE; arg = trace + (1 << FB);
      n[1] = e[5] - e[7]; n[2] = e[6] - e[2]; n[3] = e[1] - e[3];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      b = BR_X; arg = (1 << FB) + e[0] - e[4] - e[8];
      n[0] = e[5] - e[7]; n[2] = e[3] + e[1]; n[3] = e[6] + e[2];
    end else if (e[4] > e[8]) begin
      b = BR_Y; arg = (1 << FB) + e[4] - e[0] - e[8];
      n[0] = e[6] - e[2]; n[1] = e[3] + e[1]; n[3] = e[7] + e[5];
    end else begin
      b = BR_Z; arg = (1 << FB) + e[8] - e[0] - e[4];
      n[0] = e[1] - e[3]; n[1] = e[6] + e[2]; n[2] = e[7] + e[5];
    end
    n[b] = 0;
    res.degen = (arg <= 0);
    r = res.degen ? 0 : floor_sqrt(arg << FB);
    for (int k = 0; k < 4; k++)
      q[k] = (k == b) ? (res.degen ? 0 : clamp(r >> 1)) : off_term(n[k], r);
    res.qw = fix_t'(q[0]); res.qx = fix_t'(q[1]);
    res.qy = fix_t'(q[2]); res.qz = fix_t'(q[3]);
    res.br = branch_t'(b);
    return res;
  endfunction

  // directed matrices; expected typed in for identity and a full-scale diagonal
  matrix_t dir_tab [NDIR];
  quat_t dir_exp [NDIR];
  bit dir_has_exp [NDIR];

  function automatic matrix_t mk(int a0, int a1, int a2, int a3, int a4,
                                 int a5, int a6, int a7, int a8);
    matrix_t t;
    t.m[0] = fix_t'(a0); t.m[1] = fix_t'(a1); t.m[2] = fix_t'(a2);
    t.m[3] = fix_t'(a3); t.m[4] = fix_t'(a4); t.m[5] = fix_t'(a5);
    t.m[6] = fix_t'(a6); t.m[7] = fix_t'(a7); t.m[8] = fix_t'(a8);
    return t;
  endfunction

  initial begin
    for (int i = 0; i < NDIR; i++) dir_has_exp[i] = 0;
    dir_tab[0] = mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    dir_exp[0] = '{qw: 16384, qx: 0, qy: 0, qz: 0, br: BR_TRACE, degen: 0};
    dir_has_exp[0] = 1;
    dir_tab[1] = mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    dir_tab[2] = mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    dir_tab[3] = mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    dir_tab[4] = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[5] = mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    dir_tab[6] = mk(-32768, 5, -5, 7, -32768, 9, -9, 3, -32768);
    dir_exp[6] = '{qw: 0, qx: -4, qy: 3, qz: 14188, br: BR_Z, degen: 0};
    dir_has_exp[6] = 1;
    dir_tab[7] = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    dir_tab[8] = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                    -32768, -32768);
    dir_tab[9] = mk(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768);
    dir_tab[10] = mk(-100, 1, 2, 3, -100, 4, 5, 6, -200);
    dir_tab[11] = mk(-200, 1, 2, 3, -100, 4, 5, 6, -100);
    dir_tab[12] = mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
    dir_tab[13] = mk(-32768, 32767, 32767, -32768, 32767, -32768, 32767, -32768, 0);
  end

  // drive one matrix word and wait for its acceptance
  task automatic send_matrix(matrix_t a, quat_t e);
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_m[i] <= a.m[i];
    do @(posedge clk); while (!in_ready);
    quat_q.push_back(e);
  endtask

  function automatic matrix_t random_matrix();
    matrix_t t;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 4) t.m[i] = fix_t'($signed($urandom_range(0, 32768)) - 16384);
      else if (kind < 7) t.m[i] = fix_t'($signed($urandom_range(0, 4000)) - 2000);
      else t.m[i] = fix_t'($urandom);
    end
    if (kind >= 4 && kind < 7)
      t.m[4 * $urandom_range(0, 2)] = fix_t'($urandom_range(8000, 16384));
    return t;
  endfunction

  initial begin
    int burst;
    int gap;
    matrix_t a;
    quat_t e;
    rst_n = 0;
    in_valid = 0;
    for (int i = 0; i < 9; i++) in_m[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NDIR; i++) begin
      e = matrix_to_quat(dir_tab[i]);
      if (dir_has_exp[i]) e = dir_exp[i];
      send_matrix(dir_tab[i], e);
    end
    for (int n = 0; n < NRAND; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NRAND; k++, n++) begin
        a = random_matrix();
        send_matrix(a, matrix_to_quat(a));
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: stalls in phases, some long stretches always ready
  initial begin
    int mode;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        out_ready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                        : (mode == 2) ? ($urandom_range(0, 1) == 1)
                                        : ($urandom_range(0, 5) == 0);
      end
    end
  end

  always @(posedge clk) begin
    quat_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected word qw=%0d qx=%0d qy=%0d qz=%0d", $time,
                 out_qw, out_qx, out_qy, out_qz);
        errors <= errors + 1;
      end else begin
        e = quat_q.pop_front();
        if (out_qw !== e.qw || out_qx !== e.qx || out_qy !== e.qy || out_qz !== e.qz
            || out_branch_taken !== e.br || out_degenerate !== e.degen) begin
          $display("%0t: expected q=(%0d %0d %0d %0d) br=%0d dg=%0d", $time,
                   e.qw, e.qx, e.qy, e.qz, e.br, e.degen);
          $display("%0t: actual   q=(%0d %0d %0d %0d) br=%0d dg=%0d", $time,
                   out_qw, out_qx, out_qy, out_qz, out_branch_taken, out_degenerate);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    while (!(stim_done && quat_q.size() == 0)) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0)
      $display("rotation_matrix_to_quaternion_tb: PASS");
    else
      $display("rotation_matrix_to_quaternion_tb: FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("rotation_matrix_to_quaternion_tb: FAIL");
    $finish;
  end
endmodule
